// ===== hdl/ttrc_pkg.sv =====
// ttrc_pkg: shared types and constants for the three-term recurrence checksum.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ttrc_pkg;

  localparam int TermWidth   = 16;
  localparam int IndexWidth  = 8;
  localparam int ByteWidth   = 8;

  localparam int AlphaStep   = 17;
  localparam int BetaStep    = 31;
  localparam int FirstOffset = 7;
  localparam int ModM        = 65535;

  typedef logic [TermWidth-1:0]  term_t;
  typedef logic [IndexWidth-1:0] index_t;
  typedef logic [ByteWidth-1:0]  byte_t;

  localparam term_t FIRST_PREV = term_t'(1);

endpackage

// ===== hdl/ttrc_in_if.sv =====
// ttrc_in_if: byte request channel (valid/ready plus message byte and last flag).
// Depends on ttrc_pkg.
`timescale 1ns / 1ps
interface ttrc_in_if;
  logic                 valid;
  logic                 ready;
  ttrc_pkg::byte_t      data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/ttrc_out_if.sv =====
// ttrc_out_if: checksum result channel (valid/ready plus 16-bit checksum).
// Depends on ttrc_pkg.
`timescale 1ns / 1ps
interface ttrc_out_if;
  logic                 valid;
  logic                 ready;
  ttrc_pkg::term_t      checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ===== hdl/ttrc_term_calc.sv =====
// ttrc_term_calc: combinational next term of the recurrence, mod 65535.
// Two constant-coefficient products, difference with wrap correction, end-around fold.
// Depends on ttrc_pkg.
`timescale 1ns / 1ps
module ttrc_term_calc (
  input  ttrc_pkg::byte_t  data_byte,
  input  ttrc_pkg::index_t byte_index,
  input  ttrc_pkg::term_t  cur_term,
  input  ttrc_pkg::term_t  prev_term,
  output ttrc_pkg::term_t  new_term
);
  import ttrc_pkg::*;

  localparam int XWidth = ByteWidth + 1 + TermWidth;
  localparam int YWidth = IndexWidth + TermWidth;
  localparam logic [XWidth-1:0] WRAP_BIAS = XWidth'(ModM * 256 + 1);

  index_t              alpha;
  index_t              beta;
  logic [ByteWidth:0]  coef;
  logic [XWidth-1:0]   x;
  logic [YWidth-1:0]   y;
  logic [XWidth-1:0]   diff;
  logic [TermWidth:0]  fold1;
  term_t               fold2;

  always_comb begin
    alpha = IndexWidth'(byte_index * index_t'(AlphaStep));
    beta  = IndexWidth'(byte_index * index_t'(BetaStep));
    coef  = {1'b0, data_byte} + {1'b0, alpha};
    x     = XWidth'(coef) * XWidth'(cur_term);
    y     = YWidth'(beta) * YWidth'(prev_term);
    if (x >= XWidth'(y)) begin
      diff = x - XWidth'(y);
    end else begin
      diff = x + WRAP_BIAS - XWidth'(y);
    end
    // fold 2^16 = 1 mod 65535
    fold1 = {1'b0, diff[TermWidth-1:0]} + (TermWidth+1)'(diff[XWidth-1:TermWidth]);
    fold2 = fold1[TermWidth-1:0] + term_t'(fold1[TermWidth]);
    new_term = (fold2 == term_t'(ModM)) ? '0 : fold2;
  end

endmodule

// ===== hdl/ttrc_out_reg.sv =====
// ttrc_out_reg: output register stage of the checksum channel.
// Holds one result while the receiver stalls. Depends on ttrc_pkg, ttrc_out_if.
`timescale 1ns / 1ps
module ttrc_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ttrc_pkg::term_t data,
  output logic            free,
  ttrc_out_if.source      sum
);
  import ttrc_pkg::*;

  logic  valid;
  term_t checksum;

  assign free         = !valid || sum.ready;
  assign sum.valid    = valid;
  assign sum.checksum = checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
    if (free && load) begin
      checksum <= data;
    end
  end

endmodule

// ===== hdl/three_term_recurrence_checksum_unit.sv =====
// three_term_recurrence_checksum_unit: top level of the recurrence checksum.
// Depends on ttrc_pkg, ttrc_in_if, ttrc_out_if, ttrc_term_calc, ttrc_out_reg.
//
// Usage:
//   msg carries one message byte per request, with last_byte set on the final
//   byte. sum carries one 16-bit checksum per message, the recurrence term
//   after the last byte.
//   A request is taken into an input register; from there the term
//   logic updates the recurrence state, and on a last byte the checksum is
//   loaded into the output register once that register is free. The checksum
//   reaches sum through the input register and then the output register.
//   Throughput is one byte per cycle while no final byte waits, set by the
//   state update (two multiplies and an end-around fold) that each byte needs.
//   While sum is stalled, non-final bytes keep flowing; a final byte waits in
//   the input register until the output register frees.
//   Reset clears both handshake stages and returns the state to the start of
//   a message (previous term 1, current term 0, index 0, first byte expected).
`timescale 1ns / 1ps
module three_term_recurrence_checksum_unit (
  input  logic       clk,
  input  logic       rst,
  ttrc_in_if.sink    msg,
  ttrc_out_if.source sum
);
  import ttrc_pkg::*;

  logic   in_valid;
  byte_t  in_data;
  logic   in_last;

  term_t  prev_term;
  term_t  cur_term;
  index_t byte_index;
  logic   expect_first;

  term_t  new_term;
  term_t  term_next;
  logic   out_free;
  logic   advance;
  logic   emit;

  ttrc_term_calc u_calc (
    .data_byte  (in_data),
    .byte_index (byte_index),
    .cur_term   (cur_term),
    .prev_term  (prev_term),
    .new_term   (new_term)
  );

  always_comb begin
    term_next = expect_first ? (term_t'(in_data) + term_t'(FirstOffset)) : new_term;
    advance   = in_valid && (!in_last || out_free);
    emit      = advance && in_last;
  end

  assign msg.ready = !in_valid || advance;

  ttrc_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (emit),
    .data (term_next),
    .free (out_free),
    .sum  (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
    if (msg.valid && msg.ready) begin
      in_data <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_term    <= FIRST_PREV;
      cur_term     <= '0;
      byte_index   <= '0;
      expect_first <= 1'b1;
    end else if (advance) begin
      if (in_last) begin
        prev_term    <= FIRST_PREV;
        cur_term     <= '0;
        byte_index   <= '0;
        expect_first <= 1'b1;
      end else begin
        prev_term    <= expect_first ? FIRST_PREV : cur_term;
        cur_term     <= term_next;
        byte_index   <= byte_index + index_t'(1);
        expect_first <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/ttrc_checksum_checker.sv =====
// ttrc_checksum_checker: watches the byte and checksum channels, predicts each message checksum
// and compares it with the one the unit returns. Depends on ttrc_pkg, ttrc_in_if, ttrc_out_if.
`timescale 1ns / 1ps
module ttrc_checksum_checker (
  input  logic clk,
  input  logic rst,
  ttrc_in_if   msg,
  ttrc_out_if  sum,
  output int   failures,
  output int   outstanding
);
  import ttrc_pkg::*;

  term_t  prior_term;
  term_t  term;
  index_t position;
  logic   at_start;
  term_t  expected_sums[$];

  function automatic term_t recur_term(input byte_t b, input index_t i,
                                       input term_t cur, input term_t prev);
    logic [63:0] alpha;
    logic [63:0] beta;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    alpha = (64'(i) * 64'(AlphaStep)) & 64'hFF;
    beta  = (64'(i) * 64'(BetaStep)) & 64'hFF;
    x = (64'(b) + alpha) * 64'(cur);
    y = beta * 64'(prev);
    // negative difference: residue of the 64-bit wrap, 2^64 = 1 mod M
    if (x >= y) r = (x - y) % 64'(ModM);
    else        r = (x + 64'd1 + 64'(ModM) * 64'd256 - y) % 64'(ModM);
    return term_t'(r);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] checksum mismatch: %s", $time, what);
    failures = failures + 1;
  endtask

  task automatic absorb_byte(input byte_t b, input logic is_last);
    term_t next;
    if (at_start) begin
      term       = term_t'(b) + term_t'(FirstOffset);
      prior_term = FIRST_PREV;
      position   = index_t'(1);
      at_start   = 1'b0;
    end else begin
      next       = recur_term(b, position, term, prior_term);
      prior_term = term;
      term       = next;
      position   = position + index_t'(1);
    end
    if (is_last) begin
      expected_sums.push_back(term);
      prior_term = FIRST_PREV;
      term       = '0;
      position   = '0;
      at_start   = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prior_term = FIRST_PREV;
      term       = '0;
      position   = '0;
      at_start   = 1'b1;
      failures   = 0;
      expected_sums.delete();
    end else begin
      if (sum.valid && sum.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected checksum %0d", sum.checksum));
        end else begin
          if (sum.checksum !== expected_sums[0])
            report_mismatch($sformatf("got %0d, expected %0d", sum.checksum,
                                      expected_sums[0]));
          void'(expected_sums.pop_front());
        end
      end
      if (msg.valid && msg.ready) absorb_byte(msg.data_byte, msg.last_byte);
    end
    outstanding = expected_sums.size();
  end

endmodule

// ===== sim/three_term_recurrence_checksum_unit_tb.sv =====
// three_term_recurrence_checksum_unit_tb: drives byte messages with random gaps and stalls
// into the checksum unit and gives the verdict. Depends on ttrc_pkg, the channel
// interfaces, three_term_recurrence_checksum_unit and ttrc_checksum_checker.
`timescale 1ns / 1ps
module three_term_recurrence_checksum_unit_tb;
  import ttrc_pkg::*;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   items_sent = 0;
  int   tx_idle_pct = 24;
  int   rx_idle_pct = 74;

  ttrc_in_if  msg_if();
  ttrc_out_if sum_if();

  three_term_recurrence_checksum_unit DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg_if),
    .sum (sum_if)
  );

  ttrc_checksum_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg_if),
    .sum         (sum_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    sum_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      sum_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input byte_t b, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk);
    end
    msg_if.valid     <= 1'b1;
    msg_if.data_byte <= b;
    msg_if.last_byte <= is_last;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    msg_if.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic byte_t pick_byte();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  task automatic send_random_message(input int len);
    for (int k = 0; k < len; k++) send_byte(pick_byte(), k == len - 1);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int quota);
    int start;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    // long message so the byte index wraps
    send_random_message($urandom_range(257, 320));
    while (items_sent - start < quota) begin
      len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
      send_random_message(len);
      if ($urandom_range(49) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst              = 1'b1;
    msg_if.valid     = 1'b0;
    msg_if.data_byte = '0;
    msg_if.last_byte = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // single-byte messages
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF8, 1'b1);
    // short messages at the byte extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    for (int k = 0; k < 6; k++) send_byte(8'h00, k == 5);
    for (int k = 0; k < 5; k++) send_byte(8'hFF, k == 4);

    run_phase(24, 74, 640);
    run_phase(74, 24, 640);
    run_phase(0, 0, 640);

    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== three_term_recurrence_checksum_unit.f =====
hdl/ttrc_pkg.sv
hdl/ttrc_in_if.sv
hdl/ttrc_out_if.sv
hdl/ttrc_term_calc.sv
hdl/ttrc_out_reg.sv
hdl/three_term_recurrence_checksum_unit.sv
sim/ttrc_checksum_checker.sv
sim/three_term_recurrence_checksum_unit_tb.sv
